// File: hw/rtl/tpdm_pkg.sv
// Shared types, constants and a helper function for the traffic pattern destination mapper.
package tpdm_pkg;

	localparam int unsigned SRC_W      = 10;
	localparam int unsigned DEST_W     = 10;
	localparam int unsigned PATTERN_W  = 3;
	localparam int unsigned NB_W       = 4;
	localparam int unsigned RADIX_W    = 6;
	localparam int unsigned DIMS_W     = 4;
	localparam int unsigned CFG_DATA_W = 6;
	localparam int unsigned CFG_IDX_W  = 2;

	typedef enum logic [PATTERN_W-1:0] {
		PAT_BITCOMP   = 3'd0,
		PAT_TRANSPOSE = 3'd1,
		PAT_BITREV    = 3'd2,
		PAT_SHUFFLE   = 3'd3,
		PAT_TORNADO   = 3'd4,
		PAT_NEIGHBOR  = 3'd5
	} pattern_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN   = 2'd0,
		CFG_NODE_BITS = 2'd1,
		CFG_RADIX     = 2'd2,
		CFG_DIMS      = 2'd3
	} cfg_index_t;

	localparam pattern_t             PATTERN_RST   = PAT_BITCOMP;
	localparam logic [NB_W-1:0]      NODE_BITS_RST = 4'd6;
	localparam logic [RADIX_W-1:0]   RADIX_RST     = 6'd8;
	localparam logic [DIMS_W-1:0]    DIMS_RST      = 4'd2;

	typedef struct packed {
		logic [DEST_W-1:0] dest_node;
		logic              config_error;
	} result_t;

	typedef struct packed {
		logic [RADIX_W-1:0] rem;
		logic               qbit;
	} div_step_t;

	// One restoring division step: shift in one dividend bit and subtract the divisor if it fits.
	function automatic div_step_t div_step(input logic [RADIX_W-1:0] rem, input logic din,
			input logic [RADIX_W-1:0] k);
		logic [RADIX_W:0] trial;
		div_step_t        res;
		trial = {rem, din};
		if (trial >= {1'b0, k}) begin
			res.rem  = RADIX_W'(trial - {1'b0, k});
			res.qbit = 1'b1;
		end else begin
			res.rem  = trial[RADIX_W-1:0];
			res.qbit = 1'b0;
		end
		return res;
	endfunction

endpackage

// File: hw/rtl/tpdm_src_if.sv
// Request channel that carries source node numbers into the mapper.
interface tpdm_src_if;
	import tpdm_pkg::*;

	logic             valid;
	logic             ready;
	logic [SRC_W-1:0] source_node;

	modport source (output valid, output source_node, input ready);
	modport sink (input valid, input source_node, output ready);
endinterface

// File: hw/rtl/tpdm_dst_if.sv
// Result channel that carries destination node numbers and config_error out of the mapper.
interface tpdm_dst_if;
	import tpdm_pkg::*;

	logic              valid;
	logic              ready;
	logic [DEST_W-1:0] dest_node;
	logic              config_error;

	modport source (output valid, output dest_node, output config_error, input ready);
	modport sink (input valid, input dest_node, input config_error, output ready);
endinterface

// File: hw/rtl/traffic_pattern_dest_mapper.sv
// Channel   Direction  Payload                          Handshake
// src       in         source_node[9:0]                 valid/ready
// dst       out        dest_node[9:0], config_error     valid/ready
// cfg       in         cfg_index[1:0], cfg_wdata[5:0]   cfg_we, no back-pressure
//
// One request per cycle while the skid register is empty; results pass through the digit divider
// chain, which spends two pipeline stages on each radix digit.
// arst_n clears the valid bits and the skid flag, and loads the configuration defaults.
// A stalled result is parked in a one-entry skid register; src.ready drops the
// cycle after that and returns once the parked result is taken.
module traffic_pattern_dest_mapper #(
	parameter int unsigned MAX_NODE_BITS = 10,
	parameter int unsigned MAX_DIMS      = 10
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  tpdm_pkg::cfg_index_t                  cfg_index,
	input  logic [tpdm_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	tpdm_src_if.sink                              src,
	tpdm_dst_if.source                            dst
);
	import tpdm_pkg::*;

	localparam int unsigned AW     = MAX_NODE_BITS;
	localparam int unsigned NBC_W  = $clog2(AW + 1);
	localparam int unsigned CMP_W  = (NBC_W > NB_W) ? NBC_W : NB_W;
	localparam int unsigned SPLIT  = SRC_W / 2;
	localparam int unsigned NSTG   = 2 * MAX_DIMS + 1;
	localparam int unsigned PROD_W = AW + RADIX_W;

	typedef struct packed {
		logic [SRC_W-1:0]   x;
		logic [SRC_W-1:0]   q;
		logic [RADIX_W-1:0] rem;
		logic [RADIX_W-1:0] term;
		logic [AW-1:0]      acc;
		logic [AW-1:0]      wmod;
		logic [AW-1:0]      bp_dest;
		logic               err;
	} stage_t;

	// Configuration registers.
	pattern_t           pattern_q;
	logic [NB_W-1:0]    node_bits_q;
	logic [RADIX_W-1:0] radix_q;
	logic [DIMS_W-1:0]  dims_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q   <= PATTERN_RST;
			node_bits_q <= NODE_BITS_RST;
			radix_q     <= RADIX_RST;
			dims_q      <= DIMS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PATTERN:   pattern_q   <= pattern_t'(cfg_wdata[PATTERN_W-1:0]);
				CFG_NODE_BITS: node_bits_q <= cfg_wdata[NB_W-1:0];
				CFG_RADIX:     radix_q     <= cfg_wdata[RADIX_W-1:0];
				CFG_DIMS:      dims_q      <= cfg_wdata[DIMS_W-1:0];
				default:       pattern_q   <= pattern_q;
			endcase
		end
	end

	// Derived from the configuration, which the user must keep stable while requests are in flight (unenforced).
	logic [NBC_W-1:0]   nb;
	logic [NBC_W-1:0]   half;
	logic [AW-1:0]      mask;
	logic [AW-1:0]      lo_mask;
	logic               k_valid;
	logic               digit_pat;
	logic [RADIX_W-1:0] add_amt;

	always_comb begin
		nb        = (CMP_W'(node_bits_q) > CMP_W'(AW)) ? NBC_W'(AW) : NBC_W'(node_bits_q);
		half      = nb >> 1;
		mask      = ~({AW{1'b1}} << nb);
		lo_mask   = ~({AW{1'b1}} << half);
		k_valid   = radix_q > RADIX_W'(1);
		digit_pat = (pattern_q == PAT_TORNADO) || (pattern_q == PAT_NEIGHBOR);
		add_amt   = (pattern_q == PAT_TORNADO) ? ((radix_q >> 1) - RADIX_W'(1)) : RADIX_W'(1);
	end

	// Bit permutations are cheap and are resolved at entry; they ride along the pipe.
	logic [AW-1:0] s;
	logic [AW-1:0] rev;
	logic [AW-1:0] top_shift;
	logic [AW-1:0] bp_dest;
	logic          bp_err;

	always_comb begin
		s = AW'(src.source_node) & mask;
		for (int i = 0; i < AW; i++) begin
			rev[i] = s[AW-1-i];
		end
		top_shift = s >> (nb - NBC_W'(1));
		bp_err    = 1'b0;
		unique case (pattern_q)
			PAT_BITCOMP: bp_dest = ~s;
			PAT_TRANSPOSE: begin
				bp_err  = nb[0];
				bp_dest = nb[0] ? '0 : (((s >> half) & lo_mask) | ((s & lo_mask) << half));
			end
			PAT_BITREV: bp_dest = rev >> (NBC_W'(AW) - nb);
			PAT_SHUFFLE: bp_dest = (nb != '0) ? ((s << 1) | AW'(top_shift[0])) : '0;
			default: bp_dest = '0;
		endcase
	end

	// Pipeline: stage 0 is entry, then a high and a low division stage per digit.
	stage_t pipe_s     [NSTG];
	logic   pipe_vld_s [NSTG];
	stage_t stage_nxt  [NSTG];

	result_t fin_s;
	logic    fin_vld_s;
	result_t skid_q;
	logic    skid_full_q;
	logic    adv;

	assign adv       = !skid_full_q;
	assign src.ready = adv;

	always_comb begin
		stage_nxt[0].x       = src.source_node;
		stage_nxt[0].q       = '0;
		stage_nxt[0].rem     = '0;
		stage_nxt[0].term    = '0;
		stage_nxt[0].acc     = '0;
		stage_nxt[0].wmod    = AW'(1);
		stage_nxt[0].bp_dest = bp_dest;
		stage_nxt[0].err     = bp_err;
	end

	for (genvar n = 0; n < MAX_DIMS; n++) begin : g_digit
		// High half: fold in the previous digit's term and divide the upper dividend bits.
		always_comb begin
			stage_t            prev;
			stage_t            cur;
			div_step_t         st;
			logic [PROD_W-1:0] p_term;
			logic [PROD_W-1:0] p_wmod;
			prev   = pipe_s[2*n];
			cur    = prev;
			p_term = PROD_W'(prev.wmod) * PROD_W'(prev.term);
			p_wmod = PROD_W'(prev.wmod) * PROD_W'(radix_q);
			cur.acc  = prev.acc + p_term[AW-1:0];
			cur.wmod = (n == 0) ? prev.wmod : p_wmod[AW-1:0];
			cur.term = '0;
			cur.q    = '0;
			cur.rem  = '0;
			for (int j = SRC_W - 1; j >= int'(SPLIT); j--) begin
				st       = div_step(cur.rem, prev.x[j], radix_q);
				cur.rem  = st.rem;
				cur.q[j] = st.qbit;
			end
			stage_nxt[2*n+1] = cur;
		end

		// Low half: finish the division; the remainder is this digit.
		always_comb begin
			stage_t           prev;
			stage_t           cur;
			div_step_t        st;
			logic [RADIX_W:0] sum;
			prev = pipe_s[2*n+1];
			cur  = prev;
			for (int j = SPLIT - 1; j >= 0; j--) begin
				st       = div_step(cur.rem, prev.x[j], radix_q);
				cur.rem  = st.rem;
				cur.q[j] = st.qbit;
			end
			cur.x = cur.q;
			sum   = {1'b0, cur.rem} + {1'b0, add_amt};
			if (sum >= {1'b0, radix_q}) begin
				sum = sum - {1'b0, radix_q};
			end
			cur.term = (k_valid && (dims_q > DIMS_W'(n))) ? sum[RADIX_W-1:0] : '0;
			stage_nxt[2*n+2] = cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSTG; i++) begin
				pipe_vld_s[i] <= 1'b0;
			end
			fin_vld_s <= 1'b0;
		end else if (adv) begin
			pipe_vld_s[0] <= src.valid;
			for (int i = 1; i < NSTG; i++) begin
				pipe_vld_s[i] <= pipe_vld_s[i-1];
			end
			fin_vld_s <= pipe_vld_s[NSTG-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pipe_s[0] <= stage_nxt[0];
			for (int i = 1; i < NSTG; i++) begin
				pipe_s[i] <= stage_nxt[i];
			end
		end
	end

	// Final stage: last digit term, pattern select and address mask.
	result_t           fin_nxt;
	logic [PROD_W-1:0] fin_prod;
	logic [AW-1:0]     fin_acc;
	logic [AW-1:0]     fin_dest;

	always_comb begin
		fin_prod = PROD_W'(pipe_s[NSTG-1].wmod) * PROD_W'(pipe_s[NSTG-1].term);
		fin_acc  = pipe_s[NSTG-1].acc + fin_prod[AW-1:0];
		fin_dest = (digit_pat ? fin_acc : pipe_s[NSTG-1].bp_dest) & mask;
		fin_nxt.dest_node    = DEST_W'(fin_dest);
		fin_nxt.config_error = pipe_s[NSTG-1].err;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fin_s <= fin_nxt;
		end
	end

	// Skid register: holds a result the sink did not take while the pipe moved on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (dst.ready) begin
				skid_full_q <= 1'b0;
			end
		end else if (fin_vld_s && !dst.ready) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q && fin_vld_s && !dst.ready) begin
			skid_q <= fin_s;
		end
	end

	assign dst.valid        = skid_full_q || fin_vld_s;
	assign dst.dest_node    = skid_full_q ? skid_q.dest_node : fin_s.dest_node;
	assign dst.config_error = skid_full_q ? skid_q.config_error : fin_s.config_error;

endmodule

// File: tb/traffic_pattern_dest_mapper_test.sv
// Self-checking testbench for the traffic pattern destination mapper.
module traffic_pattern_dest_mapper_test;
	import tpdm_pkg::*;

	localparam int unsigned MAX_NB      = 10;
	localparam int unsigned MAX_DIGITS  = 10;
	localparam int unsigned LATENCY     = 2 * MAX_DIGITS + 2;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned SRC_MAX     = (1 << SRC_W) - 1;
	localparam logic [PATTERN_W-1:0] PAT_SPARE_A = 3'd6;
	localparam logic [PATTERN_W-1:0] PAT_SPARE_B = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_index_t            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	tpdm_src_if src_bus ();
	tpdm_dst_if dst_bus ();

	traffic_pattern_dest_mapper #(
		.MAX_NODE_BITS(MAX_NB),
		.MAX_DIMS     (MAX_DIGITS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.src      (src_bus),
		.dst      (dst_bus)
	);

	// Our copy of the mapper's registers.
	logic [PATTERN_W-1:0] cur_pattern;
	logic [NB_W-1:0]      cur_node_bits;
	logic [RADIX_W-1:0]   cur_radix;
	logic [DIMS_W-1:0]    cur_dims;

	result_t pending_routes[$];
	int      src_gap_pct;
	int      sink_stall_pct;
	int      sink_hold;
	int      mismatches;
	int      routes_checked;
	int      requests_sent;
	int      reg_writes;
	int      input_stall_cycles;
	int      cycle_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
			pending_routes.size());
		$display("traffic_pattern_dest_mapper test failed");
		$finish;
	end

	// Walks the source as base-k digits; weights wrap at 32 bits, which matches the narrower hardware sum once masked.
	function automatic int unsigned digit_walk(int unsigned src, int unsigned k,
			int unsigned nd, bit torn);
		int unsigned offset;
		int unsigned dest;
		int unsigned wmod;
		int unsigned wtrue;
		int unsigned d;
		bit          over;
		dest  = 0;
		wmod  = 1;
		wtrue = 1;
		over  = 1'b0;
		if (k < 2)
			return 0;
		offset = torn ? ((k / 2 + k - 1) % k) : (1 % k);
		for (int unsigned n = 0; n < nd; n++) begin
			d = over ? 0 : (src / wtrue) % k;
			dest += wmod * ((d + offset) % k);
			wmod *= k;
			if (!over) begin
				if (wtrue > 32'hFFFFF / k)
					over = 1'b1;
				else
					wtrue *= k;
			end
		end
		return dest;
	endfunction

	function automatic result_t route_for(logic [SRC_W-1:0] node);
		int unsigned nb;
		int unsigned nd;
		int unsigned mask;
		int unsigned s;
		int unsigned h;
		int unsigned lo;
		int unsigned dest;
		result_t     r;
		nb   = (cur_node_bits > MAX_NB) ? MAX_NB : cur_node_bits;
		nd   = (cur_dims > MAX_DIGITS) ? MAX_DIGITS : cur_dims;
		mask = (32'd1 << nb) - 1;
		s    = node & mask;
		dest = 0;
		r.config_error = 1'b0;
		case (cur_pattern)
			PAT_BITCOMP: dest = ~s;
			PAT_TRANSPOSE: begin
				if (nb % 2 == 1) begin
					r.config_error = 1'b1;
				end else begin
					h    = nb / 2;
					lo   = (32'd1 << h) - 1;
					dest = ((s >> h) & lo) | ((s & lo) << h);
				end
			end
			PAT_BITREV: begin
				for (int unsigned b = 0; b < nb; b++)
					dest |= ((s >> b) & 1) << (nb - b - 1);
			end
			PAT_SHUFFLE: begin
				if (nb > 0)
					dest = (s << 1) | ((s >> (nb - 1)) & 1);
			end
			PAT_TORNADO:  dest = digit_walk(node, cur_radix, nd, 1'b1);
			PAT_NEIGHBOR: dest = digit_walk(node, cur_radix, nd, 1'b0);
			default:      dest = 0;
		endcase
		dest &= mask;
		r.dest_node = dest[DEST_W-1:0];
		return r;
	endfunction

	// Receiver: random stalls, plus a long hold-off when a test asks for one.
	initial begin
		dst_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				dst_bus.ready <= 1'b0;
				sink_hold--;
			end else begin
				dst_bus.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
			end
		end
	end

	initial begin
		result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && src_bus.valid && !src_bus.ready)
				input_stall_cycles++;
			if (arst_n && dst_bus.valid && dst_bus.ready) begin
				if (pending_routes.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, actual dest %0d error %0b",
						$time, dst_bus.dest_node, dst_bus.config_error);
				end else begin
					want = pending_routes.pop_front();
					routes_checked++;
					if (dst_bus.dest_node !== want.dest_node) begin
						mismatches++;
						$display("%0t: dest_node expected %0d actual %0d", $time,
							want.dest_node, dst_bus.dest_node);
					end
					if (dst_bus.config_error !== want.config_error) begin
						mismatches++;
						$display("%0t: config_error expected %0b actual %0b", $time,
							want.config_error, dst_bus.config_error);
					end
				end
			end
		end
	end

	// Entered at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_source(input logic [SRC_W-1:0] node);
		while ($urandom_range(0, 99) < src_gap_pct) begin
			src_bus.valid <= 1'b0;
			@(negedge clk);
		end
		src_bus.valid       <= 1'b1;
		src_bus.source_node <= node;
		@(posedge clk);
		while (!src_bus.ready)
			@(posedge clk);
		pending_routes = {pending_routes, route_for(node)};
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic drain_pipeline();
		src_bus.valid <= 1'b0;
		while (pending_routes.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 8) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			CFG_PATTERN:   cur_pattern   = data[PATTERN_W-1:0];
			CFG_NODE_BITS: cur_node_bits = data[NB_W-1:0];
			CFG_RADIX:     cur_radix     = data[RADIX_W-1:0];
			CFG_DIMS:      cur_dims      = data[DIMS_W-1:0];
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_config(input logic [CFG_DATA_W-1:0] pat, input logic [CFG_DATA_W-1:0] nb,
			input logic [CFG_DATA_W-1:0] k, input logic [CFG_DATA_W-1:0] nd);
		drain_pipeline();
		write_reg(CFG_PATTERN, pat);
		write_reg(CFG_NODE_BITS, nb);
		write_reg(CFG_RADIX, k);
		write_reg(CFG_DIMS, nd);
	endtask

	task automatic test_reset_values();
		// Complement on six bits drops the upper source bits.
		send_source('0);
		send_source(SRC_W'(SRC_MAX));
		// Only the pattern changes, so radix 8 and two digits come from reset.
		drain_pipeline();
		write_reg(CFG_PATTERN, CFG_DATA_W'(PAT_TORNADO));
		send_source(10'd63);
	endtask

	task automatic test_bit_patterns();
		apply_config(CFG_DATA_W'(PAT_BITCOMP), 10, 8, 2);
		send_source(10'h2AA);
		apply_config(CFG_DATA_W'(PAT_TRANSPOSE), 10, 8, 2);
		send_source(10'h3E0);
		// An odd bit count cannot be transposed.
		apply_config(CFG_DATA_W'(PAT_TRANSPOSE), 9, 8, 2);
		send_source(10'h1FF);
		apply_config(CFG_DATA_W'(PAT_TRANSPOSE), 0, 8, 2);
		send_source(SRC_W'(SRC_MAX));
		// Node bits above the maximum saturate.
		apply_config(CFG_DATA_W'(PAT_BITREV), 15, 8, 2);
		send_source(10'h001);
		apply_config(CFG_DATA_W'(PAT_SHUFFLE), 10, 8, 2);
		send_source(10'h200);
		apply_config(CFG_DATA_W'(PAT_SHUFFLE), 1, 8, 2);
		send_source(SRC_W'(SRC_MAX));
		apply_config(CFG_DATA_W'(PAT_SHUFFLE), 0, 8, 2);
		send_source(10'h155);
	endtask

	task automatic test_digit_patterns();
		apply_config(CFG_DATA_W'(PAT_TORNADO), 10, 32, 2);
		send_source(SRC_W'(SRC_MAX));
		// With radix three the tornado offset is zero.
		apply_config(CFG_DATA_W'(PAT_TORNADO), 10, 3, 6);
		send_source(10'h2D9);
		apply_config(CFG_DATA_W'(PAT_NEIGHBOR), 10, 2, 10);
		send_source(10'h155);
		apply_config(CFG_DATA_W'(PAT_NEIGHBOR), 10, 0, 4);
		send_source(10'd500);
		apply_config(CFG_DATA_W'(PAT_NEIGHBOR), 10, 1, 4);
		send_source(10'd500);
		apply_config(CFG_DATA_W'(PAT_NEIGHBOR), 10, 7, 0);
		send_source(10'd500);
		// Radix to the power of dims wraps far beyond the source range.
		apply_config(CFG_DATA_W'(PAT_NEIGHBOR), 15, 63, 15);
		send_source(SRC_W'(SRC_MAX));
		apply_config(CFG_DATA_W'(PAT_TORNADO), 10, 17, 3);
		send_source(10'd777);
	endtask

	task automatic test_spare_patterns();
		apply_config(CFG_DATA_W'(PAT_SPARE_A), 10, 8, 2);
		send_source(SRC_W'(SRC_MAX));
		apply_config(CFG_DATA_W'(PAT_SPARE_B), 10, 8, 2);
		send_source(SRC_W'(SRC_MAX));
	endtask

	task automatic test_output_backpressure();
		apply_config(CFG_DATA_W'(PAT_NEIGHBOR), 10, 4, 5);
		src_gap_pct    = 0;
		sink_stall_pct = 0;
		// The sink refuses results long enough for the mapper to fill and stall its input.
		sink_hold = 300;
		repeat (80) send_source(SRC_W'($urandom_range(0, SRC_MAX)));
	endtask

	task automatic randomize_config();
		logic [CFG_DATA_W-1:0] pat;
		logic [CFG_DATA_W-1:0] nb;
		logic [CFG_DATA_W-1:0] k;
		logic [CFG_DATA_W-1:0] nd;
		// Mostly legal settings; sometimes a spare pattern or any value, and spare upper bits of the write data.
		pat = ($urandom_range(0, 9) == 0)
			? CFG_DATA_W'($urandom_range(PAT_SPARE_A, PAT_SPARE_B))
			: CFG_DATA_W'($urandom_range(PAT_BITCOMP, PAT_NEIGHBOR));
		pat[CFG_DATA_W-1:PATTERN_W] = (CFG_DATA_W - PATTERN_W)'($urandom);
		nb = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(0, 15))
			: CFG_DATA_W'($urandom_range(1, MAX_NB));
		nb[CFG_DATA_W-1:NB_W] = (CFG_DATA_W - NB_W)'($urandom);
		k = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(0, 63))
			: CFG_DATA_W'($urandom_range(2, 32));
		nd = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(0, 15))
			: CFG_DATA_W'($urandom_range(1, MAX_DIGITS));
		nd[CFG_DATA_W-1:DIMS_W] = (CFG_DATA_W - DIMS_W)'($urandom);
		apply_config(pat, nb, k, nd);
	endtask

	task automatic test_random_traffic();
		logic [SRC_W-1:0] node;
		for (int seg = 0; seg < 24; seg++) begin
			randomize_config();
			case (seg % 4)
				0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_gap_pct = 51; sink_stall_pct = 0;  end
				2: begin src_gap_pct = 0;  sink_stall_pct = 51; end
				default: begin src_gap_pct = 37; sink_stall_pct = 37; end
			endcase
			repeat (62) begin
				case ($urandom_range(0, 15))
					0:       node = '0;
					1:       node = '1;
					default: node = SRC_W'($urandom_range(0, SRC_MAX));
				endcase
				send_source(node);
			end
		end
	endtask

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = CFG_PATTERN;
		cfg_wdata           = '0;
		src_bus.valid       = 1'b0;
		src_bus.source_node = '0;
		cur_pattern         = PATTERN_RST;
		cur_node_bits       = NODE_BITS_RST;
		cur_radix           = RADIX_RST;
		cur_dims            = DIMS_RST;
		src_gap_pct         = 0;
		sink_stall_pct      = 0;
		sink_hold           = 0;
		mismatches          = 0;
		routes_checked      = 0;
		requests_sent       = 0;
		reg_writes          = 0;
		input_stall_cycles  = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_bit_patterns();
		test_digit_patterns();
		test_spare_patterns();
		test_output_backpressure();
		test_random_traffic();
		drain_pipeline();

		$display("Checked %0d of %0d requests over %0d register writes: all eight pattern codes,",
			routes_checked, requests_sent, reg_writes);
		$display("node_bits, radix and dims extremes, %0d input stall cycles, %0d mismatches.",
			input_stall_cycles, mismatches);
		if (mismatches == 0 && pending_routes.size() == 0) begin
			$display("traffic_pattern_dest_mapper test passed");
		end else begin
			$display("traffic_pattern_dest_mapper test failed");
		end
		$finish;
	end

endmodule
